// ===== hdl/mnb_pkg.sv =====
// ----------------------------------------------------------------------------
// mnb_pkg: shared types and constants of the backpropagation neuron
// Request formats, action and register codes, the sequencer states and the
// saturation helpers.
// ----------------------------------------------------------------------------
package mnb_pkg;

    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_FWD    = 3'd1,
        ACT_OUTG   = 3'd2,
        ACT_HIDG   = 3'd3,
        ACT_UPDATE = 3'd4
    } t_action;

    localparam logic [7:0] CFG_LEARNING_RATE = 8'd0;
    localparam logic [7:0] CFG_MOMENTUM      = 8'd1;

    localparam logic [15:0] LR_RESET  = 16'd9830;
    localparam logic [15:0] MOM_RESET = 16'd32768;

    localparam logic signed [17:0] ONE_Q16   = 18'sd65536;
    localparam logic signed [47:0] LIM40_Q16 = 48'sd2621440;
    localparam logic signed [47:0] HALF_SPAN = 48'sd524288;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         index;
        logic signed [31:0] value;
        logic               last;
    } t_in_req;

    typedef struct packed {
        logic signed [17:0] output_value;
        logic signed [31:0] gradient;
        logic signed [31:0] weight;
        logic               done_res;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_ACC, S_LOOK, S_ACT, S_MUL, S_GRAD,
        S_U1, S_U2, S_U3, S_U4, S_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        if (x > 50'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -50'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
        if (x > 49'sd140737488355327)
            return 48'sh7fffffffffff;
        else if (x < -49'sd140737488355328)
            return 48'sh800000000000;
        else
            return x[47:0];
    endfunction

endpackage

// ===== hdl/mnb_if.sv =====
// ----------------------------------------------------------------------------
// mnb_if: channel interfaces of the backpropagation neuron
// Input request, result request and configuration write channels.
// ----------------------------------------------------------------------------
interface mnb_in_if;
    logic             valid;
    logic             ready;
    mnb_pkg::t_in_req req;
    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

interface mnb_out_if;
    logic              valid;
    logic              ready;
    mnb_pkg::t_out_req req;
    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

interface mnb_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mnb_ram.sv =====
// ----------------------------------------------------------------------------
// mnb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mnb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/mlp_neuron_backprop_momentum_top.sv =====
// ----------------------------------------------------------------------------
// mlp_neuron_backprop_momentum_top: one trainable perceptron neuron
// Weight and delta memories, a shared multiplier and a small sequencer.
// ----------------------------------------------------------------------------
// The block takes requests on i_in (action, index, value, last) and returns
// exactly one result request on o_out for each of them. Configuration writes
// arrive on i_cfg, which is always ready; index 0 is the learning rate and
// index 1 the momentum, both unsigned Q0.16.
//
// One request is worked on at a time. i_in.ready is high only while the
// sequencer is idle. A load or an unused code goes straight to the result;
// a forward step reads the weight and accumulates the product, and the last
// element adds the table lookup and the activation. After the result is
// taken the block is ready again in the next cycle. The steps of each
// action come from the single 33 by 33 signed multiplier that all products
// pass through, each product being registered, and from the registered
// reads of the weight and delta memories and of the f and f' tables. An
// update needs four products in a row.
//
// A stalled receiver simply holds the result in the output register; no
// new request is taken until it is delivered. The synchronous reset clears
// the accumulator, the output and the gradient and restores the register
// defaults; the weight and delta memories hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module mlp_neuron_backprop_momentum_top #(
    parameter int MAX_INPUTS    = 256,
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mnb_in_if.sink    i_in,
    mnb_out_if.source o_out,
    mnb_cfg_if.sink   i_cfg
);
    import mnb_pkg::*;

    localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef logic signed [17:0] t_ftab [TABLE_ENTRIES];
    typedef logic [16:0]        t_dtab [TABLE_ENTRIES];

    // Restoring division, used only while the tables are built at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-|x| in Q30 by a Taylor series on |x|/16 and four squarings.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] m);
        logic [63:0]        a;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        s;
        a    = (m << 26) / TABLE_ENTRIES;
        term = Q30_ONE;
        sum  = $signed(Q30_ONE);
        for (int i = 1; i <= 14; i++) begin
            term = udiv64((term * a) >> 30, 64'(i));
            if (i % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        s = (sum > 0) ? $unsigned(sum) : 64'd0;
        if (s > Q30_ONE)
            s = Q30_ONE;
        for (int i = 0; i < 4; i++)
            s = (s * s + (Q30_ONE >> 1)) >> 30;
        return s;
    endfunction

    function automatic logic signed [63:0] f_entry(input int k);
        logic signed [63:0] d;
        logic [63:0]        m;
        logic [63:0]        t;
        logic [63:0]        num;
        logic [63:0]        den;
        logic signed [63:0] f;
        d   = 64'(16 * k) - 64'(8 * TABLE_ENTRIES);
        m   = (d < 0) ? $unsigned(-d) : $unsigned(d);
        t   = exp_neg_q30(m);
        num = (Q30_ONE - t) << 16;
        den = Q30_ONE + t;
        f   = $signed(udiv64(num + (den >> 1), den));
        if (d < 0)
            f = -f;
        return f;
    endfunction

    function automatic t_ftab build_f();
        t_ftab tab;
        for (int k = 0; k < TABLE_ENTRIES; k++)
            tab[k] = 18'(f_entry(k));
        return tab;
    endfunction

    function automatic t_dtab build_d();
        t_dtab tab;
        logic signed [63:0] f;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            f      = f_entry(k);
            tab[k] = 17'(((64'sd1 <<< 32) - f * f) >>> 17);
        end
        return tab;
    endfunction

    localparam t_ftab F_TAB = build_f();
    localparam t_dtab D_TAB = build_d();

    // Table index of a Q16.16 value over [-8, 8), clamped to both ends.
    function automatic logic [TW-1:0] tab_index(input logic signed [47:0] s);
        logic [63:0] p;
        if (s < -HALF_SPAN)
            return '0;
        else if (s >= HALF_SPAN)
            return TW'(TABLE_ENTRIES - 1);
        p = (64'($unsigned(s + HALF_SPAN)) * 64'(TABLE_ENTRIES)) >> 20;
        if (p >= 64'(TABLE_ENTRIES))
            return TW'(TABLE_ENTRIES - 1);
        return TW'(p);
    endfunction

    // Sequencer and datapath registers.
    t_state             r_state, n_state;
    logic [2:0]         r_act, n_act;
    logic [7:0]         r_idx, n_idx;
    logic signed [31:0] r_val, n_val;
    logic               r_last, n_last;
    logic signed [47:0] r_acc, n_acc;
    logic signed [17:0] r_out, n_out;
    logic signed [31:0] r_grad, n_grad;
    logic signed [31:0] r_wres, n_wres;
    logic               r_done, n_done;
    logic [15:0]        r_lr, r_mom;
    logic signed [65:0] r_prod;
    logic [15:0]        r_lo, n_lo;
    logic signed [47:0] r_t, n_t;
    logic signed [48:0] r_p, n_p;
    logic signed [17:0] r_ftab, n_ftab;
    logic [16:0]        r_dtab, n_dtab;
    logic               r_hi40, n_hi40;
    logic               r_lo40, n_lo40;

    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] w_rd, d_rd;
    logic               ram_re, w_we, d_we;
    logic [AW-1:0]      ram_addr;
    logic signed [31:0] w_wdata, d_wdata;
    logic               idx_ok;
    logic signed [47:0] look_src;
    logic [TW-1:0]      look_idx;
    logic signed [49:0] upd_sum;
    logic signed [31:0] new_delta;

    mnb_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS), .AW(AW)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (ram_addr),
        .i_wdata (w_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (w_rd)
    );

    mnb_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS), .AW(AW)) u_delta_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (ram_addr),
        .i_wdata (d_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (d_rd)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.req   = '{output_value: r_out, gradient: r_grad,
                           weight: r_wres, done_res: r_done};

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_idx     = r_idx;
        n_val     = r_val;
        n_last    = r_last;
        n_acc     = r_acc;
        n_out     = r_out;
        n_grad    = r_grad;
        n_wres    = r_wres;
        n_done    = r_done;
        n_lo      = r_lo;
        n_t       = r_t;
        n_p       = r_p;
        n_ftab    = r_ftab;
        n_dtab    = r_dtab;
        n_hi40    = r_hi40;
        n_lo40    = r_lo40;
        mul_a     = '0;
        mul_b     = '0;
        ram_re    = 1'b0;
        w_we      = 1'b0;
        d_we      = 1'b0;
        w_wdata   = '0;
        d_wdata   = '0;
        ram_addr  = AW'(r_idx);
        idx_ok    = (32'(r_idx) < MAX_INPUTS);
        look_src  = (r_act == ACT_FWD) ? r_acc : 48'(r_out);
        look_idx  = tab_index(look_src);
        upd_sum   = 50'(r_p) + 50'($signed(r_prod[47:16]));
        new_delta = sat32(upd_sum);

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_act    = i_in.req.action;
                    n_idx    = i_in.req.index;
                    n_val    = i_in.req.value;
                    n_last   = i_in.req.last;
                    n_wres   = '0;
                    n_done   = 1'b0;
                    ram_re   = 1'b1;
                    ram_addr = AW'(i_in.req.index);
                    idx_ok   = (32'(i_in.req.index) < MAX_INPUTS);
                    case (i_in.req.action) inside
                        ACT_LOAD: begin
                            if (idx_ok) begin
                                w_we    = 1'b1;
                                d_we    = 1'b1;
                                w_wdata = i_in.req.value;
                                n_wres  = i_in.req.value;
                            end
                            n_state = S_OUT;
                        end
                        ACT_FWD:              n_state = S_READ;
                        ACT_OUTG, ACT_HIDG:   n_state = S_LOOK;
                        ACT_UPDATE:           n_state = idx_ok ? S_READ : S_OUT;
                        default:              n_state = S_OUT;
                    endcase
                end
            end
            S_READ: begin
                mul_a = 33'(r_val);
                if (r_act == ACT_UPDATE) begin
                    mul_b   = 33'(r_grad);
                    n_state = S_U1;
                end else begin
                    mul_b   = idx_ok ? 33'(w_rd) : '0;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_acc   = sat48(49'(r_acc) + 49'($signed(r_prod[63:16])));
                n_state = r_last ? S_LOOK : S_OUT;
            end
            S_LOOK: begin
                n_ftab  = F_TAB[look_idx];
                n_dtab  = D_TAB[look_idx];
                n_hi40  = (look_src >= LIM40_Q16);
                n_lo40  = (look_src <= -LIM40_Q16);
                n_state = (r_act == ACT_FWD) ? S_ACT : S_MUL;
            end
            S_ACT: begin
                if (r_hi40)
                    n_out = ONE_Q16;
                else if (r_lo40)
                    n_out = -ONE_Q16;
                else
                    n_out = r_ftab;
                n_acc   = '0;
                n_done  = 1'b1;
                n_state = S_OUT;
            end
            S_MUL: begin
                // The derivative is zero at forty or beyond in magnitude.
                mul_a   = (r_act == ACT_OUTG) ? 33'(r_val) - 33'(r_out) : 33'(r_val);
                mul_b   = (r_hi40 || r_lo40) ? '0 : 33'(r_dtab);
                n_state = S_GRAD;
            end
            S_GRAD: begin
                n_grad  = sat32(50'($signed(r_prod[65:16])));
                n_state = S_OUT;
            end
            S_U1: begin
                // Split floor(value*gradient/2^16) into a signed upper half
                // and an unsigned lower half so each part fits the multiplier.
                n_lo    = r_prod[31:16];
                mul_a   = 33'($signed(r_prod[63:32]));
                mul_b   = 33'(r_lr);
                n_state = S_U2;
            end
            S_U2: begin
                n_t     = r_prod[47:0];
                mul_a   = 33'(r_lo);
                mul_b   = 33'(r_lr);
                n_state = S_U3;
            end
            S_U3: begin
                n_p     = 49'(r_t) + 49'(r_prod[31:16]);
                mul_a   = 33'(r_mom);
                mul_b   = 33'(d_rd);
                n_state = S_U4;
            end
            S_U4: begin
                w_we    = 1'b1;
                d_we    = 1'b1;
                d_wdata = new_delta;
                w_wdata = sat32(50'(w_rd) + 50'(new_delta));
                n_wres  = w_wdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_act  <= n_act;
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_last <= n_last;
        r_wres <= n_wres;
        r_done <= n_done;
        r_lo   <= n_lo;
        r_t    <= n_t;
        r_p    <= n_p;
        r_ftab <= n_ftab;
        r_dtab <= n_dtab;
        r_hi40 <= n_hi40;
        r_lo40 <= n_lo40;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_out   <= '0;
            r_grad  <= '0;
            r_lr    <= LR_RESET;
            r_mom   <= MOM_RESET;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_out   <= n_out;
            r_grad  <= n_grad;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_LEARNING_RATE: r_lr  <= i_cfg.data;
                    CFG_MOMENTUM:      r_mom <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end
endmodule
